>>> design/met_pkg.sv
// Shared widths, op codes and record types of the mesh edge table builder.
`default_nettype none
package met_pkg;

	// Field widths fixed by the item and result formats
	localparam int VERT_W  = 10;
	localparam int FACE_W  = 9;
	localparam int ENTRY_W = 8;
	localparam int INDEX_W = 8;
	localparam int COUNT_W = 9;
	localparam int LIMIT_W = 9;

	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 9'd256;

	// Item op codes
	localparam logic [1:0] OP_ADD   = 2'd0;
	localparam logic [1:0] OP_READ  = 2'd1;
	localparam logic [1:0] OP_CLEAR = 2'd2;

	// One stored edge: its vertex pair and its two faces
	typedef struct packed {
		logic [VERT_W-1:0] vert_first;
		logic [VERT_W-1:0] vert_second;
		logic [FACE_W-1:0] face_first;
		logic [FACE_W-1:0] face_second;
	} edge_word_t;

	// One result record
	typedef struct packed {
		logic [INDEX_W-1:0] edge_index;
		logic               was_new;
		logic               overflow;
		logic [COUNT_W-1:0] edge_count;
		logic               read_valid;
		logic [VERT_W-1:0]  read_vertex_a;
		logic [VERT_W-1:0]  read_vertex_b;
		logic [FACE_W-1:0]  read_face_first;
		logic [FACE_W-1:0]  read_face_second;
	} result_t;

endpackage
`default_nettype wire

>>> design/met_ifs.sv
// Valid/ready channel interfaces: item requests, results and the limit register write.
`default_nettype none
interface met_req_if;
	logic                        valid;
	logic                        ready;
	logic [1:0]                  op;
	logic [met_pkg::VERT_W-1:0]  vertex_a;
	logic [met_pkg::VERT_W-1:0]  vertex_b;
	logic [met_pkg::FACE_W-1:0]  face;
	logic [met_pkg::ENTRY_W-1:0] entry;

	modport source (output valid, output op, output vertex_a, output vertex_b,
		output face, output entry, input ready);
	modport sink (input valid, input op, input vertex_a, input vertex_b,
		input face, input entry, output ready);
endinterface

interface met_rsp_if;
	logic                        valid;
	logic                        ready;
	logic [met_pkg::INDEX_W-1:0] edge_index;
	logic                        was_new;
	logic                        overflow;
	logic [met_pkg::COUNT_W-1:0] edge_count;
	logic                        read_valid;
	logic [met_pkg::VERT_W-1:0]  read_vertex_a;
	logic [met_pkg::VERT_W-1:0]  read_vertex_b;
	logic [met_pkg::FACE_W-1:0]  read_face_first;
	logic [met_pkg::FACE_W-1:0]  read_face_second;

	modport source (output valid, output edge_index, output was_new, output overflow,
		output edge_count, output read_valid, output read_vertex_a, output read_vertex_b,
		output read_face_first, output read_face_second, input ready);
	modport sink (input valid, input edge_index, input was_new, input overflow,
		input edge_count, input read_valid, input read_vertex_a, input read_vertex_b,
		input read_face_first, input read_face_second, output ready);
endinterface

interface met_cfg_if;
	logic                        valid;
	logic                        ready;
	logic [met_pkg::LIMIT_W-1:0] edge_limit;

	modport source (output valid, output edge_limit, input ready);
	modport sink (input valid, input edge_limit, output ready);
endinterface
`default_nettype wire

>>> design/met_pair_cmp.sv
// Shared compare unit: unordered vertex pair match against one stored edge.
`default_nettype none
module met_pair_cmp (
	input  met_pkg::edge_word_t         stored,
	input  logic [met_pkg::VERT_W-1:0]  vert_a,
	input  logic [met_pkg::VERT_W-1:0]  vert_b,
	output logic                        hit
);

	logic same_order;
	logic swapped;

	// Either orientation of the pair counts as the same edge
	assign same_order = (stored.vert_first == vert_a) && (stored.vert_second == vert_b);
	assign swapped    = (stored.vert_first == vert_b) && (stored.vert_second == vert_a);
	assign hit        = same_order || swapped;

endmodule
`default_nettype wire

>>> design/mesh_edge_table_builder.sv
// Mesh edge table builder: sequencer, edge memory and result register.
// An add compares one stored edge a cycle: reads are issued in turn, each read is registered
// and then compared; a match or the end of the scan loads the result register, then the output.
// A read passes the READ and RDATA states; clear, an ignored add and the unused op load their
// result on acceptance. A stalled result holds the block; the next item is taken the cycle after.
// Reset clears count, flag, sequencer and output valid and sets the limit to 256; memory kept.
`default_nettype none
module mesh_edge_table_builder #(
	parameter int MAX_EDGES = 256
) (
	input  logic       clk,
	input  logic       arst_n,
	met_req_if.sink    req,
	met_rsp_if.source  rsp,
	met_cfg_if.sink    cfg
);

	localparam int IW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
	localparam int CW = $clog2(MAX_EDGES + 1);
	localparam int LW = (CW > met_pkg::LIMIT_W) ? CW : met_pkg::LIMIT_W;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_SCAN  = 3'd1;
	localparam logic [2:0] ST_READ  = 3'd2;
	localparam logic [2:0] ST_RDATA = 3'd3;
	localparam logic [2:0] ST_DONE  = 3'd4;

	// control state
	logic [2:0]                    state_q;
	logic [CW-1:0]                 count_q;
	logic                          full_q;
	logic [met_pkg::LIMIT_W-1:0]   limit_q;
	logic [CW-1:0]                 addr_q;
	logic                          cmp_v_s1;
	logic                          out_valid_q;

	// payload registers
	logic [1:0]                    op_q;
	logic [met_pkg::VERT_W-1:0]    va_q;
	logic [met_pkg::VERT_W-1:0]    vb_q;
	logic [met_pkg::FACE_W-1:0]    face_q;
	logic [met_pkg::ENTRY_W-1:0]   entry_q;
	logic [IW-1:0]                 cmp_idx_s1;
	met_pkg::edge_word_t           rd_data_q;
	met_pkg::result_t              res_q;
	met_pkg::result_t              out_q;

	met_pkg::edge_word_t           edge_mem [MAX_EDGES];

	logic                          accept;
	logic                          issue;
	logic                          pair_hit;
	logic                          hit;
	logic                          scan_end;
	logic                          room;
	logic                          upd_fire;
	logic                          ins_fire;
	logic                          ovf_fire;
	logic                          out_load;
	logic                          rd_in_range;
	logic [IW-1:0]                 rd_addr;
	logic [IW-1:0]                 wr_addr;
	logic                          wr_en;
	met_pkg::edge_word_t           wr_data;
	logic                          res_load;
	met_pkg::result_t              res_d;

	assign req.ready = (state_q == ST_IDLE);
	assign accept    = req.valid && req.ready;
	assign cfg.ready = 1'b1;

	// scan: issue one read a cycle, compare the previous read's data
	assign issue    = (state_q == ST_SCAN) && (addr_q < count_q);
	assign hit      = cmp_v_s1 && pair_hit;
	assign scan_end = (state_q == ST_SCAN) && !cmp_v_s1 && !issue;
	assign room     = !((LW'(count_q) >= LW'(limit_q)) || (count_q == CW'(MAX_EDGES)));
	assign upd_fire = (state_q == ST_SCAN) && hit;
	assign ins_fire = scan_end && room;
	assign ovf_fire = scan_end && !room;
	assign out_load = (state_q == ST_DONE) && (!out_valid_q || rsp.ready);

	met_pair_cmp u_cmp (
		.stored (rd_data_q),
		.vert_a (va_q),
		.vert_b (vb_q),
		.hit    (pair_hit)
	);

	// memory port selection
	always_comb begin
		rd_addr = IW'(entry_q);
		if (state_q == ST_SCAN) begin
			rd_addr = addr_q[IW-1:0];
		end
		wr_en   = upd_fire || ins_fire;
		wr_addr = count_q[IW-1:0];
		wr_data = '{vert_first: va_q, vert_second: vb_q, face_first: face_q,
			face_second: face_q};
		if (upd_fire) begin
			wr_addr = cmp_idx_s1;
			wr_data = '{vert_first: rd_data_q.vert_first,
				vert_second: rd_data_q.vert_second,
				face_first: rd_data_q.face_first, face_second: face_q};
		end
	end

	// edge memory, registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			edge_mem[wr_addr] <= wr_data;
		end
		rd_data_q <= edge_mem[rd_addr];
	end

	assign rd_in_range = (LW'(entry_q) < LW'(count_q));

	// next result record
	always_comb begin
		res_load            = 1'b0;
		res_d               = '0;
		res_d.overflow      = full_q;
		res_d.edge_count    = met_pkg::COUNT_W'(count_q);
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (req.op == met_pkg::OP_CLEAR) begin
						res_load         = 1'b1;
						res_d.overflow   = 1'b0;
						res_d.edge_count = '0;
					end else if (req.op != met_pkg::OP_READ) begin
						// ignored add while full, or an unused op
						res_load = (req.op != met_pkg::OP_ADD) || full_q;
					end
				end
			end
			ST_SCAN: begin
				if (upd_fire) begin
					res_load         = 1'b1;
					res_d.edge_index = met_pkg::INDEX_W'(cmp_idx_s1);
				end else if (ins_fire) begin
					res_load         = 1'b1;
					res_d.edge_index = met_pkg::INDEX_W'(count_q);
					res_d.was_new    = 1'b1;
					res_d.edge_count = met_pkg::COUNT_W'(count_q + CW'(1));
				end else if (ovf_fire) begin
					res_load       = 1'b1;
					res_d.overflow = 1'b1;
				end
			end
			ST_RDATA: begin
				res_load = 1'b1;
				if (rd_in_range) begin
					res_d.read_valid       = 1'b1;
					res_d.read_vertex_a    = rd_data_q.vert_first;
					res_d.read_vertex_b    = rd_data_q.vert_second;
					res_d.read_face_first  = rd_data_q.face_first;
					res_d.read_face_second = rd_data_q.face_second;
				end
			end
			default: begin
				res_load = 1'b0;
			end
		endcase
	end

	// sequencer and table status
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			full_q      <= 1'b0;
			limit_q     <= met_pkg::LIMIT_RESET;
			addr_q      <= '0;
			cmp_v_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg.valid) begin
				limit_q <= cfg.edge_limit;
			end
			cmp_v_s1 <= issue;
			if (issue) begin
				addr_q <= addr_q + CW'(1);
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						addr_q <= '0;
						case (req.op)
							met_pkg::OP_ADD: begin
								state_q <= full_q ? ST_DONE : ST_SCAN;
							end
							met_pkg::OP_READ: begin
								state_q <= ST_READ;
							end
							met_pkg::OP_CLEAR: begin
								count_q <= '0;
								full_q  <= 1'b0;
								state_q <= ST_DONE;
							end
							default: begin
								state_q <= ST_DONE;
							end
						endcase
					end
				end
				ST_SCAN: begin
					if (upd_fire || scan_end) begin
						state_q <= ST_DONE;
					end
					if (ins_fire) begin
						count_q <= count_q + CW'(1);
					end
					if (ovf_fire) begin
						full_q <= 1'b1;
					end
				end
				ST_READ: begin
					state_q <= ST_RDATA;
				end
				ST_RDATA: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// item capture, compare index pipeline and result registers
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q    <= req.op;
			va_q    <= req.vertex_a;
			vb_q    <= req.vertex_b;
			face_q  <= req.face;
			entry_q <= req.entry;
		end
		cmp_idx_s1 <= addr_q[IW-1:0];
		if (res_load) begin
			res_q <= res_d;
		end
		if (out_load) begin
			out_q <= res_q;
		end
	end

	assign rsp.valid            = out_valid_q;
	assign rsp.edge_index       = out_q.edge_index;
	assign rsp.was_new          = out_q.was_new;
	assign rsp.overflow         = out_q.overflow;
	assign rsp.edge_count       = out_q.edge_count;
	assign rsp.read_valid       = out_q.read_valid;
	assign rsp.read_vertex_a    = out_q.read_vertex_a;
	assign rsp.read_vertex_b    = out_q.read_vertex_b;
	assign rsp.read_face_first  = out_q.read_face_first;
	assign rsp.read_face_second = out_q.read_face_second;

	// checks
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_EDGES))
		else $error("edge count beyond table depth");

	a_cmp_in_table: assert property (@(posedge clk) disable iff (!arst_n)
		cmp_v_s1 |-> (CW'(cmp_idx_s1) < count_q))
		else $error("compare on an entry above the count");

	a_insert_count: assert property (@(posedge clk) disable iff (!arst_n)
		ins_fire |=> (count_q == $past(count_q) + CW'(1)))
		else $error("insert did not advance the count");

	a_full_from_scan: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(full_q) |-> ($past(state_q) == ST_SCAN))
		else $error("overflow flag set outside a scan");

	a_op_add_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (op_q == met_pkg::OP_ADD))
		else $error("scan running for a non-add item");

endmodule
`default_nettype wire
